FILE: hw/rtl/lcg48_pkg.sv
// ============================================================================
// lcg48_pkg - shared constants for the 48-bit LCG random generator
// Widths, generator constants and request codes used by all blocks.
// ============================================================================
package lcg48_pkg;

    localparam int STATE_W = 48;
    localparam int HALF_W  = 24;
    localparam int MULT_W  = 35;
    localparam int NB_W    = 6;
    localparam int BOUND_W = 31;
    localparam int VALUE_W = 64;
    localparam int REQ_W   = 2;

    localparam logic [MULT_W-1:0]  LCG_MULT = 35'h5_DEEC_E66D;
    localparam logic [STATE_W-1:0] LCG_ADD  = 48'hB;

    // request codes
    localparam logic [REQ_W-1:0] REQ_RAW  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BND  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LONG = 2'd2;
    localparam logic [REQ_W-1:0] REQ_DBL  = 2'd3;

endpackage

FILE: hw/rtl/lcg48_stream_if.sv
// ============================================================================
// lcg48 stream interfaces
// Valid/ready channels for requests and for drawn values.
// ============================================================================
interface lcg48_req_if;
    logic                                valid;
    logic                                ready;
    logic [lcg48_pkg::REQ_W-1:0]         req_type;
    logic [lcg48_pkg::NB_W-1:0]          bit_count;
    logic [lcg48_pkg::BOUND_W-1:0]       bound;

    modport source (output valid, output req_type, output bit_count, output bound,
                    input ready);
    modport sink   (input valid, input req_type, input bit_count, input bound,
                    output ready);
endinterface

interface lcg48_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [lcg48_pkg::VALUE_W-1:0]       value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

FILE: hw/rtl/lcg48_random_generator_unit.sv
// ============================================================================
// lcg48_random_generator_unit - 48-bit LCG random generator
// Sequencer around a shared LCG step unit and an iterative remainder unit.
// ============================================================================
// Usage:
//   req  : request beats (req_type, bit_count, bound). ready is high only
//          while the sequencer is idle; one request is worked at a time.
//   rsp  : one 64-bit value beat per request, held in an output register.
//   seed_we / seed_wdata : a write loads state = seed xor 0x5DEECE66D.
//          Write only when no request is in flight.
// Work per request: an LCG step runs on the shared 24x35 multiplier and the
// remainder is found bit-serially:
//   raw draw            : an LCG step
//   long / double       : two LCG steps
//   bounded, power of 2 : an LCG step, then a scale by n
//   bounded, other n    : an LCG step and a remainder, again for each rejected draw
// Requests do not overlap: a new one is accepted only once the last value has left the sequencer.
// Reset puts the state at 0 xor multiplier and empties the output register.
// When the receiver stalls, the finished value waits in the output register;
// the next request is still accepted and worked, and its value waits in the
// sequencer until the output register frees up.
// ============================================================================
module lcg48_random_generator_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    lcg48_req_if.sink                          req,
    lcg48_rsp_if.source                        rsp,
    input  logic                               seed_we,
    input  logic [lcg48_pkg::STATE_W-1:0]      seed_wdata
);

    localparam int SW = lcg48_pkg::STATE_W;
    localparam int BW = lcg48_pkg::BOUND_W;
    localparam int VW = lcg48_pkg::VALUE_W;
    localparam int NW = lcg48_pkg::NB_W;

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DRAW = 3'd1;   // waiting on LCG step
    localparam logic [2:0] S_MOD  = 3'd2;   // waiting on remainder
    localparam logic [2:0] S_POW  = 3'd3;   // power-of-two scale
    localparam logic [2:0] S_DONE = 3'd4;   // result waits for output slot

    logic [2:0]                  state_reg, state_next;
    logic [SW-1:0]               lcg_reg, lcg_next;
    logic [lcg48_pkg::REQ_W-1:0] req_reg, req_next;
    logic [NW-1:0]               nb_reg, nb_next;
    logic [BW-1:0]               bound_reg, bound_next;
    logic [BW-1:0]               d31_reg, d31_next;
    logic [VW-1:0]               acc_reg, acc_next;
    logic [VW-1:0]               res_reg, res_next;
    logic                        second_reg, second_next;
    logic                        out_valid_reg, out_valid_next;
    logic [VW-1:0]               out_value_reg, out_value_next;

    logic                        accept;
    logic                        step_start, step_done;
    logic [SW-1:0]               step_result;
    logic                        mod_start, mod_done;
    logic [BW-1:0]               mod_rem;
    logic [31:0]                 d32;
    logic [4:0]                  raw_shift;
    logic                        pow2;
    logic [BW:0]                 reject_sum;
    logic [2*BW-1:0]             pow_prod;
    logic [NW-1:0]               nb_sat;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    // saturate bit count to 1..32
    always_comb
    begin
        nb_sat = req.bit_count;
        if (req.bit_count == '0)
        begin
            nb_sat = NW'(1);
        end
        else if (req.bit_count > NW'(32))
        begin
            nb_sat = NW'(32);
        end
    end

    assign d32        = step_result[SW-1:SW-32];
    assign raw_shift  = 5'(NW'(32) - nb_reg);
    assign pow2       = ((bound_reg & (bound_reg - BW'(1))) == '0);
    // published rejection test: d - val + (n - 1) > 2^31 - 1
    assign reject_sum = {1'b0, d31_reg} - {1'b0, mod_rem} + {1'b0, bound_reg}
                      - (BW+1)'(1);
    assign pow_prod   = (2*BW)'(bound_reg) * (2*BW)'(d31_reg);

    always_comb
    begin
        state_next     = state_reg;
        lcg_next       = lcg_reg;
        req_next       = req_reg;
        nb_next        = nb_reg;
        bound_next     = bound_reg;
        d31_next       = d31_reg;
        acc_next       = acc_reg;
        res_next       = res_reg;
        second_next    = second_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        step_start     = 1'b0;
        mod_start      = 1'b0;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next    = req.req_type;
                    nb_next     = nb_sat;
                    bound_next  = req.bound;
                    second_next = 1'b0;
                    step_start  = 1'b1;
                    state_next  = S_DRAW;
                end
            end
            S_DRAW:
            begin
                if (step_done)
                begin
                    lcg_next = step_result;
                    unique case (req_reg)
                        lcg48_pkg::REQ_RAW:
                        begin
                            res_next   = VW'(d32 >> raw_shift);
                            state_next = S_DONE;
                        end
                        lcg48_pkg::REQ_BND:
                        begin
                            d31_next = step_result[SW-1:SW-BW];
                            if (pow2)
                            begin
                                state_next = S_POW;
                            end
                            else
                            begin
                                mod_start  = 1'b1;
                                state_next = S_MOD;
                            end
                        end
                        lcg48_pkg::REQ_LONG:
                        begin
                            if (!second_reg)
                            begin
                                acc_next    = {d32, 32'd0};
                                second_next = 1'b1;
                                step_start  = 1'b1;
                            end
                            else
                            begin
                                res_next   = acc_reg + {{32{d32[31]}}, d32};
                                state_next = S_DONE;
                            end
                        end
                        lcg48_pkg::REQ_DBL:
                        begin
                            if (!second_reg)
                            begin
                                acc_next    = VW'(step_result[SW-1:SW-26]);
                                second_next = 1'b1;
                                step_start  = 1'b1;
                            end
                            else
                            begin
                                res_next   = {11'd0, acc_reg[25:0], step_result[SW-1:SW-27]};
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    if (reject_sum > (BW+1)'(32'h7FFF_FFFF))
                    begin
                        step_start = 1'b1;
                        state_next = S_DRAW;
                    end
                    else
                    begin
                        res_next   = VW'(mod_rem);
                        state_next = S_DONE;
                    end
                end
            end
            S_POW:
            begin
                res_next   = VW'(pow_prod[2*BW-1:BW]);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (seed_we)
        begin
            lcg_next = seed_wdata ^ SW'(lcg48_pkg::LCG_MULT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lcg_reg       <= SW'(lcg48_pkg::LCG_MULT);
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lcg_reg       <= lcg_next;
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        nb_reg        <= nb_next;
        bound_reg     <= bound_next;
        d31_reg       <= d31_next;
        acc_reg       <= acc_next;
        res_reg       <= res_next;
        out_value_reg <= out_value_next;
    end

    // the step unit takes the state as it is written this cycle
    lcg48_step u_step
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (step_start),
        .state_in (lcg_next),
        .done     (step_done),
        .result   (step_result)
    );

    lcg48_mod u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (step_result[SW-1:SW-BW]),
        .divisor   (bound_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign rsp.valid = out_valid_reg;
    assign rsp.value = out_value_reg;

endmodule

FILE: hw/rtl/lcg48_step.sv
// ============================================================================
// lcg48_step - one LCG advance
// state*MULT + ADD mod 2^48 on a shared 24x35 multiplier, two passes.
// ============================================================================
module lcg48_step
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [lcg48_pkg::STATE_W-1:0]      state_in,
    output logic                               done,
    output logic [lcg48_pkg::STATE_W-1:0]      result
);

    localparam int PROD_W = lcg48_pkg::HALF_W + lcg48_pkg::MULT_W;

    logic                              phase_reg;
    logic [lcg48_pkg::HALF_W-1:0]      hi_reg;
    logic [lcg48_pkg::STATE_W-1:0]     part_reg;
    logic [lcg48_pkg::STATE_W-1:0]     result_reg;
    logic                              done_reg;
    logic [lcg48_pkg::HALF_W-1:0]      mul_a;
    logic [PROD_W-1:0]                 mul_p;

    // pass 0: low half times full multiplier; pass 1: high half, low 24 bits kept
    assign mul_a = phase_reg ? hi_reg : state_in[lcg48_pkg::HALF_W-1:0];
    assign mul_p = PROD_W'(mul_a) * PROD_W'(lcg48_pkg::LCG_MULT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (phase_reg)
            begin
                phase_reg <= 1'b0;
                done_reg  <= 1'b1;
            end
            else if (start)
            begin
                phase_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg)
        begin
            result_reg <= part_reg
                        + {mul_p[lcg48_pkg::HALF_W-1:0], {lcg48_pkg::HALF_W{1'b0}}}
                        + lcg48_pkg::LCG_ADD;
        end
        else if (start)
        begin
            part_reg <= mul_p[lcg48_pkg::STATE_W-1:0];
            hi_reg   <= state_in[lcg48_pkg::STATE_W-1:lcg48_pkg::HALF_W];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: hw/rtl/lcg48_mod.sv
// ============================================================================
// lcg48_mod - iterative remainder
// Restoring division, one dividend bit per cycle, remainder only.
// ============================================================================
module lcg48_mod
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [lcg48_pkg::BOUND_W-1:0]      dividend,
    input  logic [lcg48_pkg::BOUND_W-1:0]      divisor,
    output logic                               done,
    output logic [lcg48_pkg::BOUND_W-1:0]      remainder
);

    localparam int W     = lcg48_pkg::BOUND_W;
    localparam int CNT_W = $clog2(W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     rem_reg;
    logic [W:0]       trial;
    logic [W:0]       diff;
    logic [W-1:0]     rem_next;

    assign trial    = {rem_reg, quo_reg[W-1]};
    assign diff     = trial - {1'b0, divisor};
    assign rem_next = (trial >= {1'b0, divisor}) ? diff[W-1:0] : trial[W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W - 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[W-2:0], 1'b0};
        end
        else if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top - testbench for lcg48_random_generator_unit
// Drives request beats and seed writes, predicts every drawn value from its
// own copy of the 48-bit generator state, and checks each response beat in
// order. Both channels idle and stall at random.
// ============================================================================

typedef struct packed {
    logic [lcg48_pkg::REQ_W-1:0]   req_type;
    logic [lcg48_pkg::NB_W-1:0]    bit_count;
    logic [lcg48_pkg::BOUND_W-1:0] bound;
} lcg48_request_t;

// Tracks the generator state and the values still owed by the block.
class lcg48_draw_ledger;
    localparam int STATE_W = lcg48_pkg::STATE_W;
    localparam int VALUE_W = lcg48_pkg::VALUE_W;

    bit [STATE_W-1:0] gen_state;
    bit [VALUE_W-1:0] owed_values[$];
    int               errors;

    function new();
        errors = 0;
        reseed('0);
    endfunction

    function void reseed(bit [STATE_W-1:0] seed);
        gen_state = seed ^ STATE_W'(lcg48_pkg::LCG_MULT);
    endfunction

    // advance the state and hand out its top nbits
    function bit [VALUE_W-1:0] next_bits(int nbits);
        gen_state = gen_state * STATE_W'(lcg48_pkg::LCG_MULT) + lcg48_pkg::LCG_ADD;
        return VALUE_W'(gen_state) >> (STATE_W - nbits);
    endfunction

    function bit [VALUE_W-1:0] drawn_value(lcg48_request_t r);
        bit [VALUE_W-1:0] n;
        bit [VALUE_W-1:0] d;
        bit [VALUE_W-1:0] rem;
        bit [VALUE_W-1:0] hi;
        bit [VALUE_W-1:0] lo;
        int               nb;
        case (r.req_type)
            lcg48_pkg::REQ_RAW:
            begin
                nb = int'(r.bit_count);
                if (nb == 0)
                    nb = 1;
                if (nb > 32)
                    nb = 32;
                return next_bits(nb);
            end
            lcg48_pkg::REQ_BND:
            begin
                n = VALUE_W'(r.bound);
                // zero falls into the power-of-two path and gives 0
                if ((n & (n - 1)) == 0)
                    return (n * next_bits(31)) >> 31;
                do
                begin
                    d   = next_bits(31);
                    rem = d % n;
                end while (d - rem + (n - 1) > 64'h7FFF_FFFF);
                return rem;
            end
            lcg48_pkg::REQ_LONG:
            begin
                hi = next_bits(32);
                lo = next_bits(32);
                return (hi << 32) + {{32{lo[31]}}, lo[31:0]};
            end
            default:
            begin
                hi = next_bits(26);
                lo = next_bits(27);
                return (hi << 27) + lo;
            end
        endcase
    endfunction

    function void note_request(lcg48_request_t r);
        owed_values.push_back(drawn_value(r));
    endfunction

    function void check_value(bit [VALUE_W-1:0] got);
        bit [VALUE_W-1:0] want;
        if (owed_values.size() == 0)
        begin
            errors++;
            if (errors <= 50)
                $display("%0t: unexpected beat, expected none, actual %h", $time, got);
            return;
        end
        want = owed_values.pop_front();
        if (got !== want)
        begin
            errors++;
            if (errors <= 50)
                $display("%0t: value mismatch, expected %h, actual %h", $time, want, got);
        end
    endfunction
endclass

module tb_top;

    localparam int STATE_W = lcg48_pkg::STATE_W;
    localparam int VALUE_W = lcg48_pkg::VALUE_W;
    localparam int REQ_W   = lcg48_pkg::REQ_W;
    localparam int NB_W    = lcg48_pkg::NB_W;
    localparam int BOUND_W = lcg48_pkg::BOUND_W;

    localparam int LONG_HOLD   = 300;   // receiver hold-off, in cycles
    localparam int STALL_LIMIT = 6000;  // cycles with no beat on either side
    localparam int TAIL_CYCLES = 60;    // settle time after the last value

    logic                clk;
    logic                rst_n;
    logic                seed_we;
    logic [STATE_W-1:0]  seed_wdata;

    lcg48_req_if req_if ();
    lcg48_rsp_if rsp_if ();

    lcg48_draw_ledger ledger = new();

    // shared knobs between the stimulus and the receiver
    bit sink_idling;
    bit hold_receiver;

    lcg48_random_generator_unit DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_if),
        .rsp        (rsp_if),
        .seed_we    (seed_we),
        .seed_wdata (seed_wdata)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic lcg48_request_t make_request(logic [REQ_W-1:0] kind,
                                                    logic [NB_W-1:0] nb,
                                                    logic [BOUND_W-1:0] n);
        lcg48_request_t r;
        r.req_type  = kind;
        r.bit_count = nb;
        r.bound     = n;
        return r;
    endfunction

    // Bounded requests get the largest share of the weight since they carry the rejection
    // loop; bounds mix small, power-of-two, zero, worst-rejection and full range.
    function automatic lcg48_request_t random_request();
        lcg48_request_t r;
        int             pick;
        pick        = $urandom_range(0, 9);
        r.req_type  = (pick < 4) ? lcg48_pkg::REQ_BND :
                      (pick < 6) ? lcg48_pkg::REQ_RAW :
                      (pick < 8) ? lcg48_pkg::REQ_LONG : lcg48_pkg::REQ_DBL;
        r.bit_count = NB_W'($urandom_range(0, 63));
        case ($urandom_range(0, 7))
            0:       r.bound = BOUND_W'($urandom_range(1, 16));
            1:       r.bound = BOUND_W'(1) << $urandom_range(0, 30);
            2:       r.bound = '0;
            3:       r.bound = BOUND_W'(32'h4000_0000 + $urandom_range(1, 64));
            4, 5:    r.bound = BOUND_W'($urandom);
            6:       r.bound = BOUND_W'(32'h7FFF_FFFF - $urandom_range(0, 255));
            default: r.bound = BOUND_W'($urandom_range(1, 1000));
        endcase
        return r;
    endfunction

    // Holds valid high until the beat is taken; valid is left high so the
    // next beat can follow back to back. ready is looked at mid-cycle, where
    // it holds the value the next rising edge sees.
    task automatic send_request(lcg48_request_t r);
        req_if.valid     <= 1'b1;
        req_if.req_type  <= r.req_type;
        req_if.bit_count <= r.bit_count;
        req_if.bound     <= r.bound;
        @(negedge clk);
        while (!req_if.ready)
            @(negedge clk);
        @(posedge clk);
        ledger.note_request(r);
    endtask

    task automatic pause_sender(int cycles);
        req_if.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Stop offering and wait until every owed value is back and the
    // sequencer shows idle again.
    task automatic drain();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (ledger.owed_values.size() != 0 || !req_if.ready);
    endtask

    task automatic write_seed(logic [STATE_W-1:0] seed);
        drain();
        repeat (8) @(posedge clk);
        seed_we    <= 1'b1;
        seed_wdata <= seed;
        @(posedge clk);
        seed_we    <= 1'b0;
        ledger.reseed(seed);
    endtask

    // hold_at < 0 means no long receiver hold in this run;
    // pause_at < 0 means no mid-run drain
    task automatic run_random(int count, bit idling, int hold_at, int pause_at);
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
                hold_receiver = 1'b1;
            if (i == pause_at)
                drain();
            else if (idling && $urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 12));
            send_request(random_request());
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: samples the value channel mid-cycle, checks a beat taken at
    // the following edge and decides ready for the next one.
    // A long hold is requested by the stimulus and counted down here.
    // ------------------------------------------------------------------------
    initial
    begin
        int               stall_left;
        bit               take;
        bit [VALUE_W-1:0] seen;
        stall_left = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            take = rst_n && rsp_if.valid && rsp_if.ready;
            seen = rsp_if.value;
            @(posedge clk);
            if (take)
                ledger.check_value(seen);
            if (hold_receiver)
            begin
                stall_left    = LONG_HOLD;
                hold_receiver = 1'b0;
            end
            else if (stall_left == 0 && sink_idling && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 12);
            if (stall_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: gives up after a long run of edges with no beat anywhere.
    // ------------------------------------------------------------------------
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(negedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n            <= 1'b0;
        seed_we          <= 1'b0;
        seed_wdata       <= '0;
        req_if.valid     <= 1'b0;
        req_if.req_type  <= lcg48_pkg::REQ_RAW;
        req_if.bit_count <= '0;
        req_if.bound     <= '0;
        sink_idling      = 1'b0;
        hold_receiver    = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, from the reset state: bit-count saturation at both ends,
        // bound of zero and of one, powers of two, the worst rejection bound
        // just above 2^30, the largest bound, and both two-draw requests.
        send_request(make_request(lcg48_pkg::REQ_RAW, 6'd0, BOUND_W'($urandom)));
        send_request(make_request(lcg48_pkg::REQ_RAW, 6'd1, '0));
        send_request(make_request(lcg48_pkg::REQ_RAW, 6'd31, '1));
        send_request(make_request(lcg48_pkg::REQ_RAW, 6'd32, '0));
        send_request(make_request(lcg48_pkg::REQ_RAW, 6'd33, '1));
        send_request(make_request(lcg48_pkg::REQ_RAW, 6'd63, '0));
        send_request(make_request(lcg48_pkg::REQ_BND, 6'd0, 31'd1));
        send_request(make_request(lcg48_pkg::REQ_BND, 6'd63, 31'd0));
        send_request(make_request(lcg48_pkg::REQ_BND, 6'd0, 31'd2));
        send_request(make_request(lcg48_pkg::REQ_BND, 6'd0, 31'h4000_0000));
        send_request(make_request(lcg48_pkg::REQ_BND, 6'd0, 31'd3));
        send_request(make_request(lcg48_pkg::REQ_BND, 6'd0, 31'h4000_0001));
        send_request(make_request(lcg48_pkg::REQ_BND, 6'd0, 31'h4000_0001));
        send_request(make_request(lcg48_pkg::REQ_BND, 6'd0, 31'h7FFF_FFFF));
        send_request(make_request(lcg48_pkg::REQ_BND, 6'd0, 31'd100));
        send_request(make_request(lcg48_pkg::REQ_LONG, 6'd63, '1));
        send_request(make_request(lcg48_pkg::REQ_LONG, 6'd0, '0));
        send_request(make_request(lcg48_pkg::REQ_DBL, 6'd0, '1));
        send_request(make_request(lcg48_pkg::REQ_DBL, 6'd63, '0));

        // seed zero, idling on both sides, one mid-run drain
        write_seed('0);
        sink_idling = 1'b1;
        run_random(300, 1'b1, -1, 150);

        // all-ones seed; the receiver holds off long while requests keep coming
        write_seed('1);
        run_random(300, 1'b1, 100, -1);

        // seed equal to the multiplier puts the state at zero
        write_seed(STATE_W'(lcg48_pkg::LCG_MULT));
        send_request(make_request(lcg48_pkg::REQ_RAW, 6'd32, '0));
        send_request(make_request(lcg48_pkg::REQ_LONG, 6'd0, '0));
        send_request(make_request(lcg48_pkg::REQ_DBL, 6'd0, '0));
        send_request(make_request(lcg48_pkg::REQ_BND, 6'd0, 31'h7FFF_FFFF));
        run_random(300, 1'b1, -1, -1);

        write_seed(STATE_W'({$urandom, $urandom}));
        run_random(500, 1'b1, 250, -1);

        // last part: no idling on either side
        write_seed(STATE_W'({$urandom, $urandom}));
        sink_idling = 1'b0;
        run_random(500, 1'b0, -1, -1);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (ledger.owed_values.size() != 0)
        begin
            $display("%0t: %0d values never arrived", $time, ledger.owed_values.size());
            ledger.errors++;
        end
        if (ledger.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
